>>> hdl/gpr_pkg.sv
// gpr_pkg: shared types, register codes and field helpers of the gpio port register block
// used by gpr_lock, gpr_regfile, gpio_port_register_block and the testbench; no dependencies
`default_nettype none

package gpr_pkg;

	localparam int PIN_COUNT_DEF = 16;
	localparam int MAX_PINS      = 16;
	localparam int LOCK_KEY_BIT  = 16;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef enum logic [3:0] {
		REG_MODE     = 4'd0,
		REG_OTYPE    = 4'd1,
		REG_SPEED    = 4'd2,
		REG_PULL     = 4'd3,
		REG_INPUT    = 4'd4,
		REG_OUTPUT   = 4'd5,
		REG_SETRESET = 4'd6,
		REG_LOCK     = 4'd7,
		REG_AFLOW    = 4'd8,
		REG_AFHIGH   = 4'd9
	} reg_sel_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic [15:0] pad_levels;
	} access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] out_levels;
		logic [15:0] drive_enable;
		logic        lock_active;
		logic        ignored;
	} result_t;

	// lock state as seen by the register file
	typedef struct packed {
		logic        locked;
		logic        locked_nxt;
		logic [15:0] mask;
	} lock_stat_t;

	function automatic logic [15:0] pins_present(input int count);
		logic [15:0] r;
		for (int i = 0; i < MAX_PINS; i++) begin
			r[i] = (i < count);
		end
		return r;
	endfunction

	// one pin bit becomes a 2-bit field
	function automatic logic [31:0] spread2(input logic [15:0] m);
		logic [31:0] r;
		for (int i = 0; i < MAX_PINS; i++) begin
			r[2*i +: 2] = {2{m[i]}};
		end
		return r;
	endfunction

	// one pin bit becomes a 4-bit field, eight pins per word
	function automatic logic [31:0] spread4(input logic [7:0] m);
		logic [31:0] r;
		for (int i = 0; i < 8; i++) begin
			r[4*i +: 4] = {4{m[i]}};
		end
		return r;
	endfunction

	// general output mode is field value 01
	function automatic logic [15:0] drive_mask(input logic [31:0] mode);
		logic [15:0] r;
		for (int i = 0; i < MAX_PINS; i++) begin
			r[i] = (mode[2*i +: 2] == 2'b01);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/gpr_lock.sv
// gpr_lock: lock key sequencer, lock mask and lock flag of the port
// depends on gpr_pkg
`default_nettype none

module gpr_lock #(
	parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire logic [16:0]        wdata,
	output gpr_pkg::lock_stat_t     stat
);

	localparam logic [15:0] PinMask = gpr_pkg::pins_present(PIN_COUNT);

	typedef enum logic [2:0] {
		KEY_IDLE = 3'b001,
		KEY_ONE  = 3'b010,
		KEY_ZERO = 3'b100
	} key_state_t;

	key_state_t  key_q, key_d;
	logic [15:0] mask_q, mask_d;
	logic        locked_q, locked_d;
	logic        key_bit;
	logic [15:0] wmask;
	logic        same_mask;

	assign key_bit   = wdata[gpr_pkg::LOCK_KEY_BIT];
	assign wmask     = wdata[15:0] & PinMask;
	assign same_mask = (wmask == mask_q);

	always_comb begin
		key_d    = key_q;
		mask_d   = mask_q;
		locked_d = locked_q;
		if (wr && !locked_q) begin
			// any break in the sequence restarts it from this write
			mask_d = wmask;
			key_d  = key_bit ? KEY_ONE : KEY_IDLE;
			case (key_q)
				KEY_ONE: begin
					if (!key_bit && same_mask) begin
						mask_d = mask_q;
						key_d  = KEY_ZERO;
					end
				end
				KEY_ZERO: begin
					if (key_bit && same_mask) begin
						mask_d   = mask_q;
						key_d    = KEY_IDLE;
						locked_d = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= KEY_IDLE;
			mask_q   <= '0;
			locked_q <= 1'b0;
		end else begin
			key_q    <= key_d;
			mask_q   <= mask_d;
			locked_q <= locked_d;
		end
	end

	assign stat.locked     = locked_q;
	assign stat.locked_nxt = locked_d;
	assign stat.mask       = mask_q;

endmodule

`default_nettype wire

>>> hdl/gpr_regfile.sv
// gpr_regfile: configuration registers, output latch, read mux and write guarding
// depends on gpr_pkg; lock state comes from gpr_lock
`default_nettype none

module gpr_regfile #(
	parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire gpr_pkg::access_t    item,
	input  wire gpr_pkg::lock_stat_t lstat,
	output gpr_pkg::result_t         res
);

	localparam logic [15:0] PinMask  = gpr_pkg::pins_present(PIN_COUNT);
	localparam logic [31:0] Impl2    = gpr_pkg::spread2(PinMask);
	localparam logic [31:0] ImplLo   = gpr_pkg::spread4(PinMask[7:0]);
	localparam logic [31:0] ImplHi   = gpr_pkg::spread4(PinMask[15:8]);

	logic [31:0] mode_q, speed_q, pull_q, aflow_q, afhigh_q;
	logic [15:0] otype_q, out_q;
	logic [31:0] mode_d, speed_d, pull_d, aflow_d, afhigh_d;
	logic [15:0] otype_d, out_d;
	logic [31:0] rd;
	logic        flag;
	logic [15:0] fp;
	logic [31:0] fz2, fzlo, fzhi;
	logic [31:0] wd;

	// {flag, new value}: frozen bits keep old contents
	function automatic logic [32:0] guard(input logic [31:0] old, input logic [31:0] w,
			input logic [31:0] impl, input logic [31:0] frozen);
		logic        f;
		logic [31:0] v;
		f = |((old ^ w) & frozen);
		v = (old & frozen) | (w & impl & ~frozen);
		return {f, v};
	endfunction

	assign wd   = item.write_data;
	assign fp   = lstat.locked ? (lstat.mask & PinMask) : '0;
	assign fz2  = gpr_pkg::spread2(fp);
	assign fzlo = gpr_pkg::spread4(fp[7:0]);
	assign fzhi = gpr_pkg::spread4(fp[15:8]);

	always_comb begin
		mode_d   = mode_q;
		speed_d  = speed_q;
		pull_d   = pull_q;
		aflow_d  = aflow_q;
		afhigh_d = afhigh_q;
		otype_d  = otype_q;
		out_d    = out_q;
		rd       = '0;
		flag     = 1'b0;
		if (item.kind == gpr_pkg::KIND_WRITE) begin
			case (gpr_pkg::reg_sel_t'(item.reg_index))
				gpr_pkg::REG_MODE:   {flag, mode_d}   = guard(mode_q, wd, Impl2, fz2);
				gpr_pkg::REG_SPEED:  {flag, speed_d}  = guard(speed_q, wd, Impl2, fz2);
				gpr_pkg::REG_PULL:   {flag, pull_d}   = guard(pull_q, wd, Impl2, fz2);
				gpr_pkg::REG_AFLOW:  {flag, aflow_d}  = guard(aflow_q, wd, ImplLo, fzlo);
				gpr_pkg::REG_AFHIGH: {flag, afhigh_d} = guard(afhigh_q, wd, ImplHi, fzhi);
				gpr_pkg::REG_OTYPE: begin
					flag    = |((otype_q ^ wd[15:0]) & fp);
					otype_d = (otype_q & fp) | (wd[15:0] & PinMask & ~fp);
				end
				gpr_pkg::REG_OUTPUT:   out_d = wd[15:0] & PinMask;
				// set half wins over reset half
				gpr_pkg::REG_SETRESET: out_d = ((out_q & ~wd[31:16]) | wd[15:0]) & PinMask;
				gpr_pkg::REG_LOCK:     flag = lstat.locked;
				default:               flag = 1'b1;
			endcase
		end else begin
			case (gpr_pkg::reg_sel_t'(item.reg_index))
				gpr_pkg::REG_MODE:   rd = mode_q;
				gpr_pkg::REG_OTYPE:  rd = {16'b0, otype_q};
				gpr_pkg::REG_SPEED:  rd = speed_q;
				gpr_pkg::REG_PULL:   rd = pull_q;
				gpr_pkg::REG_INPUT:  rd = {16'b0, item.pad_levels & PinMask};
				gpr_pkg::REG_OUTPUT: rd = {16'b0, out_q};
				gpr_pkg::REG_LOCK:   rd = {15'b0, lstat.locked, lstat.mask};
				gpr_pkg::REG_AFLOW:  rd = aflow_q;
				gpr_pkg::REG_AFHIGH: rd = afhigh_q;
				default:             rd = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			speed_q  <= '0;
			pull_q   <= '0;
			aflow_q  <= '0;
			afhigh_q <= '0;
			otype_q  <= '0;
			out_q    <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			speed_q  <= speed_d;
			pull_q   <= pull_d;
			aflow_q  <= aflow_d;
			afhigh_q <= afhigh_d;
			otype_q  <= otype_d;
			out_q    <= out_d;
		end
	end

	assign res.read_data    = rd;
	assign res.out_levels   = out_d;
	assign res.drive_enable = gpr_pkg::drive_mask(mode_d) & PinMask;
	assign res.lock_active  = lstat.locked_nxt;
	assign res.ignored      = flag;

endmodule

`default_nettype wire

>>> hdl/gpio_port_register_block.sv
// gpio_port_register_block: top level of one GPIO port register block with configuration lock
// depends on gpr_pkg, gpr_lock and gpr_regfile
`default_nettype none

// One bus transaction per clock while not stalled: each access is captured in an input register,
// then decoded and applied to the port registers when it advances, and at that same time its result
// (read data, output latch, output enables, lock flag and the ignored flag) is captured in the
// result register. Throughput is one access per cycle, set by the single register
// update path; access_stall rises only when both the input and result registers are full and
// result_stall is high. Output levels, enables and lock flag in a result reflect the state
// after that access. PIN_COUNT (1 to 16) sets how many pins exist; bits of absent pins read
// as zero and are never stored.
module gpio_port_register_block #(
	parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             access_valid,
	output      logic             access_stall,
	input  wire gpr_pkg::access_t access,
	output      logic             result_valid,
	input  wire logic             result_stall,
	output gpr_pkg::result_t      result
);

	localparam logic [15:0] PinMask = gpr_pkg::pins_present(PIN_COUNT);

	logic                valid_s1;
	gpr_pkg::access_t    access_s1;
	logic                result_valid_q;
	gpr_pkg::result_t    result_q;
	gpr_pkg::result_t    res_d;
	gpr_pkg::lock_stat_t lstat;
	logic                advance;
	logic                lock_wr;

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign access_stall = valid_s1 && !advance;
	assign lock_wr      = advance && (access_s1.kind == gpr_pkg::KIND_WRITE)
		&& (gpr_pkg::reg_sel_t'(access_s1.reg_index) == gpr_pkg::REG_LOCK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (access_valid && !access_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (access_valid && !access_stall) begin
			access_s1 <= access;
		end
	end

	gpr_lock #(
		.PIN_COUNT(PIN_COUNT)
	) u_lock (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (lock_wr),
		.wdata (access_s1.write_data[16:0]),
		.stat  (lstat)
	);

	gpr_regfile #(
		.PIN_COUNT(PIN_COUNT)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (access_s1),
		.lstat  (lstat),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// the lock only clears on reset
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lstat.locked |=> lstat.locked)
		else $error("lock flag cleared without reset");

	a_read_not_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (access_s1.kind == gpr_pkg::KIND_READ) |=> !result_q.ignored)
		else $error("read transaction flagged ignored");

	a_enable_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> ((result_q.drive_enable & ~PinMask) == 16'h0000))
		else $error("drive enable on an absent pin");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		access_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule

`default_nettype wire

>>> test/gpio_port_register_block_tb.sv
// gpio_port_register_block_tb: self-checking bench for the gpio port register block, one
// access per transaction, each result checked against an in-bench port model
// depends on gpr_pkg and gpio_port_register_block
`timescale 1ns / 1ps

module gpio_port_register_block_tb;

	localparam int NPINS = gpr_pkg::PIN_COUNT_DEF;
	localparam logic [15:0] PINS = 16'((32'd1 << NPINS) - 32'd1);
	localparam int LO_CNT = (NPINS > 8) ? 8 : NPINS;
	localparam int HI_CNT = (NPINS > 8) ? NPINS - 8 : 0;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [2:0] {
		KEY_IDLE      = 3'b001,
		KEY_ARMED     = 3'b010,
		KEY_CONFIRMED = 3'b100
	} key_step_t;

	typedef struct {
		gpr_pkg::access_t pkt;
		int unsigned      gap;
		bit               drain_first;
	} bus_item_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             access_valid = 1'b0;
	logic             access_stall;
	gpr_pkg::access_t access = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	gpr_pkg::result_t result;

	bus_item_t        bus_accesses[$];
	gpr_pkg::result_t port_replies[$];
	int unsigned idle_cycles = 0;
	int unsigned hold_left = 0;
	int unsigned replies_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// port model state
	logic [31:0] mode_r, speed_r, pull_r, aflo_r, afhi_r;
	logic [15:0] otype_r, outl_r, lmask_r;
	logic        lkey_r;
	key_step_t   kstep_r;

	gpio_port_register_block DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.access_valid (access_valid),
		.access_stall (access_stall),
		.access       (access),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// per-pin mask widened to w-bit fields for pins first..first+cnt-1
	function automatic logic [31:0] widen(input logic [15:0] m, input int w, input int first,
		input int cnt);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < cnt; i++) begin
			if (m[first + i])
				r |= ((w == 4) ? 32'hF : 32'h3) << (i * w);
		end
		return r;
	endfunction

	function automatic logic [31:0] keep_frozen(input logic [31:0] cur, input logic [31:0] wd,
		input logic [31:0] impl, input logic [31:0] frozen, inout logic hit);
		if (((cur ^ wd) & frozen) != 0)
			hit = 1'b1;
		return (cur & frozen) | (wd & impl & ~frozen);
	endfunction

	function automatic void apply_access(input gpr_pkg::access_t a,
		output gpr_pkg::result_t r);
		logic [15:0] fp;
		logic [15:0] m;
		logic [15:0] drv;
		logic [31:0] rd;
		logic [31:0] wd;
		logic        hit;
		fp = lkey_r ? (lmask_r & PINS) : 16'h0;
		wd = a.write_data;
		rd = '0;
		hit = 1'b0;
		if (a.kind == gpr_pkg::KIND_READ) begin
			case (a.reg_index)
				gpr_pkg::REG_MODE:   rd = mode_r;
				gpr_pkg::REG_OTYPE:  rd = {16'h0, otype_r};
				gpr_pkg::REG_SPEED:  rd = speed_r;
				gpr_pkg::REG_PULL:   rd = pull_r;
				gpr_pkg::REG_INPUT:  rd = {16'h0, a.pad_levels & PINS};
				gpr_pkg::REG_OUTPUT: rd = {16'h0, outl_r};
				gpr_pkg::REG_LOCK:   rd = {15'h0, lkey_r, lmask_r};
				gpr_pkg::REG_AFLOW:  rd = aflo_r;
				gpr_pkg::REG_AFHIGH: rd = afhi_r;
				default:             rd = '0;
			endcase
		end else begin
			case (a.reg_index)
				gpr_pkg::REG_MODE: mode_r = keep_frozen(mode_r, wd,
					widen(PINS, 2, 0, NPINS), widen(fp, 2, 0, NPINS), hit);
				gpr_pkg::REG_OTYPE: otype_r = 16'(keep_frozen({16'h0, otype_r}, wd,
					{16'h0, PINS}, {16'h0, fp}, hit));
				gpr_pkg::REG_SPEED: speed_r = keep_frozen(speed_r, wd,
					widen(PINS, 2, 0, NPINS), widen(fp, 2, 0, NPINS), hit);
				gpr_pkg::REG_PULL: pull_r = keep_frozen(pull_r, wd,
					widen(PINS, 2, 0, NPINS), widen(fp, 2, 0, NPINS), hit);
				gpr_pkg::REG_OUTPUT: outl_r = wd[15:0] & PINS;
				// set half wins over reset half
				gpr_pkg::REG_SETRESET: outl_r = ((outl_r & ~wd[31:16]) | wd[15:0]) & PINS;
				gpr_pkg::REG_LOCK: begin
					m = wd[15:0] & PINS;
					if (lkey_r)
						hit = 1'b1;
					else if (kstep_r == KEY_ARMED && !wd[gpr_pkg::LOCK_KEY_BIT]
						&& m == lmask_r)
						kstep_r = KEY_CONFIRMED;
					else if (kstep_r == KEY_CONFIRMED && wd[gpr_pkg::LOCK_KEY_BIT]
						&& m == lmask_r) begin
						lkey_r = 1'b1;
						kstep_r = KEY_IDLE;
					end else begin
						lmask_r = m;
						kstep_r = wd[gpr_pkg::LOCK_KEY_BIT] ? KEY_ARMED : KEY_IDLE;
					end
				end
				gpr_pkg::REG_AFLOW: aflo_r = keep_frozen(aflo_r, wd,
					widen(PINS, 4, 0, LO_CNT), widen(fp, 4, 0, LO_CNT), hit);
				gpr_pkg::REG_AFHIGH: afhi_r = keep_frozen(afhi_r, wd,
					widen(PINS, 4, 8, HI_CNT), widen(fp, 4, 8, HI_CNT), hit);
				default: hit = 1'b1;
			endcase
		end
		drv = '0;
		for (int p = 0; p < 16; p++) begin
			drv[p] = (mode_r[2*p +: 2] == 2'b01);
		end
		r.read_data = rd;
		r.out_levels = outl_r;
		r.drive_enable = drv & PINS;
		r.lock_active = lkey_r;
		r.ignored = hit;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("reply %0d: %s is %h, predicted %h", replies_seen, what, got, want);
	endtask

	task automatic queue_access(input logic kind, input logic [3:0] idx, input logic [31:0] wd,
		input logic [15:0] pads, input bit drain);
		bus_item_t it;
		it.pkt.kind = kind;
		it.pkt.reg_index = idx;
		it.pkt.write_data = wd;
		it.pkt.pad_levels = pads;
		// every fourth stretch of 64 goes back to back
		it.gap = ((bus_accesses.size() / 64) % 4 == 2) ? 0 : $urandom_range(0, 11);
		it.drain_first = drain;
		bus_accesses.push_back(it);
	endtask

	task automatic queue_random(input bit lock_writes);
		logic       kind;
		logic [3:0] idx;
		logic [31:0] wd;
		kind = ($urandom_range(0, 1) != 0) ? gpr_pkg::KIND_WRITE : gpr_pkg::KIND_READ;
		idx = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
		if (!lock_writes && kind == gpr_pkg::KIND_WRITE && idx == gpr_pkg::REG_LOCK)
			kind = gpr_pkg::KIND_READ;
		case ($urandom_range(0, 5))
			0:       wd = '0;
			1:       wd = '1;
			2:       wd = 32'h5555_5555 ^ ($urandom & $urandom);
			default: wd = $urandom;
		endcase
		queue_access(kind, idx, wd, 16'($urandom), 1'b0);
	endtask

	task automatic queue_lock_write(input logic key, input logic [15:0] m, input bit drain);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_LOCK, {15'($urandom), key, m},
			16'($urandom), drain);
		if ($urandom_range(0, 2) == 0)
			queue_random(1'b0);
	endtask

	// key sequence that never completes; two key-0 writes always end at the idle step
	task automatic queue_broken_lock();
		logic [15:0] m;
		logic [15:0] m2;
		m = 16'($urandom);
		m2 = m ^ 16'(1 << $urandom_range(0, 15));
		case ($urandom_range(0, 4))
			0: begin
				queue_lock_write(1'b1, m, 1'b0);
				queue_lock_write(1'b0, m2, 1'b0);
			end
			1: begin
				queue_lock_write(1'b1, m, 1'b0);
				queue_lock_write(1'b1, m, 1'b0);
			end
			2: begin
				queue_lock_write(1'b1, m, 1'b0);
				queue_lock_write(1'b0, m, 1'b0);
				queue_lock_write(1'b1, m2, 1'b0);
			end
			3: begin
				queue_lock_write(1'b1, m, 1'b0);
				queue_lock_write(1'b0, m, 1'b0);
				queue_lock_write(1'b0, m, 1'b0);
			end
			default: queue_lock_write(1'b0, m, 1'b0);
		endcase
		queue_lock_write(1'b0, 16'($urandom), 1'b0);
		queue_lock_write(1'b0, 16'($urandom), 1'b0);
	endtask

	// driver: presents queued accesses, predicts each one as it is accepted
	always @(posedge clk) begin
		gpr_pkg::result_t predicted;
		logic             fire;
		if (arst_n) begin
			fire = access_valid && !access_stall;
			if (!access_valid)
				idle_cycles++;
			if (fire) begin
				apply_access(access, predicted);
				port_replies.push_back(predicted);
				idle_cycles = 0;
			end
			if (!access_valid || fire) begin
				if (bus_accesses.size() != 0 && idle_cycles >= bus_accesses[0].gap &&
				    (!bus_accesses[0].drain_first || port_replies.size() == 0)) begin
					access <= bus_accesses[0].pkt;
					access_valid <= 1'b1;
					void'(bus_accesses.pop_front());
				end else begin
					access_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction, then draws its own stall
	always @(posedge clk) begin
		gpr_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (port_replies.size() == 0) begin
					report_mismatch("unrequested read_data", result.read_data, '0);
				end else begin
					want = port_replies.pop_front();
					if (result.read_data !== want.read_data)
						report_mismatch("read_data", result.read_data, want.read_data);
					if (result.out_levels !== want.out_levels)
						report_mismatch("out_levels", {16'h0, result.out_levels},
							{16'h0, want.out_levels});
					if (result.drive_enable !== want.drive_enable)
						report_mismatch("drive_enable", {16'h0, result.drive_enable},
							{16'h0, want.drive_enable});
					if (result.lock_active !== want.lock_active)
						report_mismatch("lock_active", {31'h0, result.lock_active},
							{31'h0, want.lock_active});
					if (result.ignored !== want.ignored)
						report_mismatch("ignored", {31'h0, result.ignored},
							{31'h0, want.ignored});
				end
				replies_seen++;
				// long hold-off lets the block back up into the access side
				if (replies_seen == 150 || replies_seen == 600)
					hold_left = 160;
				else if ((replies_seen / 80) % 4 == 3)
					hold_left = 0;
				else
					hold_left = $urandom_range(0, 11);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			result_stall <= (hold_left != 0);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [15:0] lock_pins;
		mode_r = '0;
		speed_r = '0;
		pull_r = '0;
		aflo_r = '0;
		afhi_r = '0;
		otype_r = '0;
		outl_r = '0;
		lmask_r = '0;
		lkey_r = 1'b0;
		kstep_r = KEY_IDLE;

		// directed: reset values, field extremes, set/reset priority, read-only and unused
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_MODE, '1, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_INPUT, '0, 16'hFFFF, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_INPUT, '1, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_MODE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_MODE, 32'h5555_5555, 16'hFFFF, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_MODE, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_OTYPE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_OTYPE, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_SPEED, 32'hAAAA_AAAA, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_PULL, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_AFLOW, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_AFHIGH, 32'h1234_5678, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_AFLOW, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_AFHIGH, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_OUTPUT, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_SETRESET, 32'hFFFF_FFFF, 16'h0000,
			1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_SETRESET, 32'hFFFF_0000, 16'h0000,
			1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_SETRESET, 32'h0000_A5A5, 16'h0000,
			1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_OUTPUT, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_SETRESET, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_INPUT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, 4'hF, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_READ, 4'hA, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_LOCK, '0, 16'h0000, 1'b0);
		queue_access(gpr_pkg::KIND_WRITE, gpr_pkg::REG_MODE, 32'h0000_0000, 16'h0000, 1'b0);

		// unlocked: random traffic with interrupted key sequences
		for (int i = 0; i < 300; i++) begin
			if ($urandom_range(0, 7) == 0)
				queue_broken_lock();
			else
				queue_random(1'b0);
		end

		// full key sequence after the pipeline has drained; both frozen and free pins
		lock_pins = (16'($urandom) | 16'h0001) & 16'h7FFF;
		queue_lock_write(1'b1, lock_pins, 1'b1);
		queue_lock_write(1'b0, lock_pins, 1'b0);
		queue_lock_write(1'b1, lock_pins, 1'b0);
		queue_access(gpr_pkg::KIND_READ, gpr_pkg::REG_LOCK, '0, 16'h0000, 1'b0);

		// locked: frozen-field writes and ignored lock writes
		for (int i = 0; i < 330; i++) begin
			queue_random(1'b1);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (bus_accesses.size() != 0 || access_valid)
			@(posedge clk);
		while (port_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
